/* sv/ikt_pkg.sv */
// Shared types, keyword table and keyword match function for the tokenizer.
`default_nettype none
package ikt_pkg;

	localparam int MAX_KEYWORD_LEN_DEF = 10;
	localparam int POS_WIDTH_DEF       = 32;
	localparam int LEN_WIDTH_DEF       = 16;

	localparam int KW_BYTES = 10;   // longest keyword
	localparam int KW_COUNT = 39;
	localparam int KIND_W   = 6;
	localparam int SLEN_W   = 4;
	localparam int START_W  = 32;
	localparam int LENGTH_W = 16;

	localparam logic [KIND_W-1:0] KIND_IDENT = '0;

	// Keyword text, right-aligned, first character in the highest used byte.
	localparam logic [KW_BYTES*8-1:0] KW_LIT [KW_COUNT] = '{
		80'("let"), 80'("const"), 80'("function"), 80'("class"), 80'("interface"),
		80'("enum"), 80'("typedef"), 80'("namespace"), 80'("if"), 80'("else"),
		80'("for"), 80'("while"), 80'("do"), 80'("break"), 80'("continue"),
		80'("return"), 80'("true"), 80'("false"), 80'("null"), 80'("undefined"),
		80'("this"), 80'("void"), 80'("int"), 80'("float"), 80'("boolean"),
		80'("string"), 80'("try"), 80'("catch"), 80'("switch"), 80'("case"),
		80'("default"), 80'("extends"), 80'("implements"), 80'("public"),
		80'("private"), 80'("protected"), 80'("new"), 80'("throw"), 80'("typeof")
	};

	localparam logic [SLEN_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd5, 4'd8, 4'd5, 4'd9, 4'd4, 4'd7, 4'd9, 4'd2, 4'd4,
		4'd3, 4'd5, 4'd2, 4'd5, 4'd8, 4'd6, 4'd4, 4'd5, 4'd4, 4'd9,
		4'd4, 4'd4, 4'd3, 4'd5, 4'd7, 4'd6, 4'd3, 4'd5, 4'd6, 4'd4,
		4'd7, 4'd7, 4'd10, 4'd6, 4'd7, 4'd9, 4'd3, 4'd5, 4'd6
	};

	// Finished word on its way to the keyword compare.
	typedef struct packed {
		logic [KW_BYTES-1:0][7:0] text;       // text[0] is the first byte
		logic [SLEN_W-1:0]        short_len;  // word length, 0 if too long
		logic [START_W-1:0]       start;
		logic [LENGTH_W-1:0]      length;
	} token_t;

	function automatic logic [KIND_W-1:0] kw_kind(
		input logic [KW_BYTES-1:0][7:0] text,
		input logic [SLEN_W-1:0]        len
	);
		logic [KIND_W-1:0] kind;
		logic              hit;
		logic [7:0]        ch;
		kind = KIND_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (len == KW_LEN[k]);
			for (int i = 0; i < KW_BYTES; i++) begin
				if (i < int'(KW_LEN[k])) begin
					ch = KW_LIT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8];
					if (text[i] != ch)
						hit = 1'b0;
				end
			end
			if (hit && kind == KIND_IDENT)
				kind = KIND_W'(k + 1);
		end
		return kind;
	endfunction

endpackage
`default_nettype wire

/* sv/identifier_keyword_tokenizer.sv */
// Top level of the identifier and keyword tokenizer.
// Usage:
//   Input channel (in_valid/in_ready): one source byte per request, char_code
//   plus end_of_text on the last byte of the stream. Every byte advances the
//   stream position, word byte or not.
//   Output channel (out_valid/out_ready): one token per finished word with
//   token_kind (0 identifier, 1..39 keyword), token_start and token_length.
//   A word ends on the first non-word byte or on a byte flagged end_of_text.
// Path: the token of a finished word goes from the scan register through
//   the keyword compare into the output reg.
// Throughput: one byte per cycle while the output is not held, set by the
//   combinational scan update and the parallel 39-way keyword compare.
// Stall: with the output held and the token register full, in_ready drops;
//   it stays high as long as the token register can move on.
// Reset: arst_n clears word state, position counter and both valid flags;
//   the prefix buffer is not cleared (only bytes written for the current
//   word are ever compared).
`default_nettype none
module identifier_keyword_tokenizer #(
	parameter int MAX_KEYWORD_LEN = ikt_pkg::MAX_KEYWORD_LEN_DEF,
	parameter int POS_WIDTH       = ikt_pkg::POS_WIDTH_DEF,
	parameter int LEN_WIDTH       = ikt_pkg::LEN_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [7:0]              char_code,
	input  wire logic                    end_of_text,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [ikt_pkg::KIND_W-1:0]   token_kind,
	output logic [ikt_pkg::START_W-1:0]  token_start,
	output logic [ikt_pkg::LENGTH_W-1:0] token_length
);
	import ikt_pkg::*;

	logic   tok_valid;
	logic   tok_take;
	token_t tok;

	// scan stage: word tracking, one token register
	ikt_scan #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
		.POS_WIDTH      (POS_WIDTH),
		.LEN_WIDTH      (LEN_WIDTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.tok_valid  (tok_valid),
		.tok        (tok),
		.tok_take   (tok_take)
	);

	// match stage: keyword lookup, result register
	ikt_match u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_valid   (tok_valid),
		.tok         (tok),
		.tok_take    (tok_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length)
	);

	// input only blocks when both stages are full and the output is stalled
	a_ready_blocks_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (tok_valid && out_valid && !out_ready))
		else $error("in_ready low without a full pipeline");

	// a token moved into the output register is shown next cycle
	a_take_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take |=> out_valid)
		else $error("token taken but output not valid");

	// keywords have lengths between two and the longest keyword
	a_keyword_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_kind != KIND_IDENT) |->
		(token_length >= LENGTH_W'(2) && token_length <= LENGTH_W'(KW_BYTES)))
		else $error("keyword token with impossible length");

	// kind code stays within the keyword list
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (token_kind <= KIND_W'(KW_COUNT)))
		else $error("token kind out of range");

endmodule
`default_nettype wire

/* sv/ikt_scan.sv */
// Byte scanner: word state, position counter, prefix buffer, token register.
`default_nettype none
module ikt_scan #(
	parameter int MAX_KEYWORD_LEN = ikt_pkg::MAX_KEYWORD_LEN_DEF,
	parameter int POS_WIDTH       = ikt_pkg::POS_WIDTH_DEF,
	parameter int LEN_WIDTH       = ikt_pkg::LEN_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    char_code,
	input  wire logic          end_of_text,
	output logic               tok_valid,
	output ikt_pkg::token_t    tok,
	input  wire logic          tok_take
);
	import ikt_pkg::*;

	localparam int IDX_W = $clog2(MAX_KEYWORD_LEN);
	localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	logic                 inside_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] begin_q;
	logic [LEN_WIDTH-1:0] count_q;
	logic [7:0]           prefix_q [MAX_KEYWORD_LEN];
	logic                 valid_s1;
	token_t               tok_s1;

	logic                 accept;
	logic                 letter, word_byte;
	logic                 cont, term, start;
	logic                 upd_inside, emit;
	logic [LEN_WIDTH-1:0] upd_count;
	logic [POS_WIDTH-1:0] upd_begin;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	token_t               tok_nxt;

	assign in_ready = !valid_s1 || tok_take;
	assign accept   = in_valid && in_ready;

	always_comb begin
		letter     = is_letter(char_code);
		word_byte  = letter || is_digit(char_code);
		cont       = inside_q && word_byte;
		term       = inside_q && !word_byte;
		start      = !inside_q && letter;
		upd_inside = start || cont;
		emit       = term || (end_of_text && upd_inside);

		if (start)
			upd_count = LEN_WIDTH'(1);
		else if (cont && count_q != LEN_MAX)
			upd_count = count_q + LEN_WIDTH'(1);
		else
			upd_count = count_q;
		upd_begin = start ? pos_q : begin_q;

		// prefix slot 0 on a start, next free slot while the word is short
		wr_en  = start || (cont && count_q < LEN_WIDTH'(MAX_KEYWORD_LEN));
		wr_idx = start ? '0 : count_q[IDX_W-1:0];

		for (int i = 0; i < KW_BYTES; i++)
			tok_nxt.text[i] = (wr_en && wr_idx == IDX_W'(i)) ? char_code : prefix_q[i];
		tok_nxt.short_len = (upd_count <= LEN_WIDTH'(KW_BYTES)) ? upd_count[SLEN_W-1:0] : '0;
		tok_nxt.start     = START_W'(upd_begin);
		tok_nxt.length    = LENGTH_W'(upd_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			pos_q    <= '0;
			begin_q  <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				inside_q <= upd_inside && !end_of_text;
				pos_q    <= pos_q + POS_WIDTH'(1);
				begin_q  <= upd_begin;
				count_q  <= end_of_text ? '0 : upd_count;
				valid_s1 <= emit;
			end else if (tok_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en)
			prefix_q[wr_idx] <= char_code;
		if (accept && emit)
			tok_s1 <= tok_nxt;
	end

	assign tok_valid = valid_s1;
	assign tok       = tok_s1;

endmodule
`default_nettype wire

/* sv/ikt_match.sv */
// Keyword compare and output register.
`default_nettype none
module ikt_match (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tok_valid,
	input  wire ikt_pkg::token_t               tok,
	output logic                               tok_take,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ikt_pkg::KIND_W-1:0]         token_kind,
	output logic [ikt_pkg::START_W-1:0]        token_start,
	output logic [ikt_pkg::LENGTH_W-1:0]       token_length
);
	import ikt_pkg::*;

	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [START_W-1:0]  start_q;
	logic [LENGTH_W-1:0] length_q;

	assign tok_take = tok_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (tok_take)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (tok_take) begin
			kind_q   <= kw_kind(tok.text, tok.short_len);
			start_q  <= tok.start;
			length_q <= tok.length;
		end
	end

	assign out_valid    = out_valid_q;
	assign token_kind   = kind_q;
	assign token_start  = start_q;
	assign token_length = length_q;

endmodule
`default_nettype wire
